// File: src/lsle_pkg.sv
// ============================================================================
// lsle_pkg
// Shared sizes and action codes for the least-squares linear extrapolator.
// ============================================================================
package lsle_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int CHANNELS      = 8;

    localparam int CH_W     = 3;
    localparam int POS_W    = $clog2(HISTORY_DEPTH);
    localparam int ADDR_W   = CH_W + POS_W;
    localparam int MEM_DEPTH = CHANNELS * HISTORY_DEPTH;

    localparam int SAMPLE_W = 32;
    localparam int WGT_W    = 6;
    localparam int PROD_W   = SAMPLE_W + WGT_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int CNT_W    = 4;

    localparam logic [1:0] ACT_PUSH    = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_EXTRAP  = 2'd2;

    typedef logic [POS_W-1:0] pos_t;

endpackage

// File: src/least_squares_linear_extrapolator.sv
// ============================================================================
// least_squares_linear_extrapolator
// Per-channel sample rings with a shared write position; least-squares
// prediction of the next sample of a channel over its last 4 or 8 samples.
// ============================================================================
// Push and advance transfers finish in the cycle they are accepted. An
// extrapolate transfer (N = 4 or 8) holds s_tready low while the ring is read
// one sample a cycle through a registered read port into one shared
// multiplier, the read, product and accumulate stages drain, the division by
// N(N-1) shifts out the factor of four or eight and one reciprocal multiplier
// divides the rest by three or seven a digit at a time, and the result goes
// to the output register; no new request is taken meanwhile, and the wait is
// longer while an earlier result is still held by m_tready. The result waits
// in an output register, so new input is taken while it is still pending.
// The history reads as zero after reset through per-entry valid bits; no
// clearing pass.
module least_squares_linear_extrapolator
    import lsle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // channel[2:0], sample[34:3], zero pad
    input  logic [2:0]  s_tuser,   // action[1:0], use_eight_points[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // prediction[31:0]
    output logic        m_tuser    // saturated
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIT  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    localparam logic signed [WGT_W-1:0] WGT_STEP = WGT_W'(6);
    localparam logic signed [WGT_W-1:0] WGT0_4   = WGT_W'(2 - 2 * 4);
    localparam logic signed [WGT_W-1:0] WGT0_8   = WGT_W'(2 - 2 * 8);

    logic [1:0]          in_action;
    logic [CH_W-1:0]     in_channel;
    logic [SAMPLE_W-1:0] in_sample;
    logic                in_eight;
    logic                in_xfer;
    logic                ch_ok;
    logic [CNT_W-1:0]    in_n;

    assign in_action  = s_tuser[1:0];
    assign in_eight   = s_tuser[2];
    assign in_channel = s_tdata[CH_W-1:0];
    assign in_sample  = s_tdata[CH_W +: SAMPLE_W];
    assign in_xfer    = s_tvalid && s_tready;
    assign ch_ok      = {1'b0, in_channel} < (CH_W + 1)'(CHANNELS);
    assign in_n       = in_eight ? CNT_W'(8) : CNT_W'(4);

    logic [2:0]                state_reg, state_next;
    pos_t                      wp_reg, wp_next;
    pos_t                      idx_reg, idx_next;
    logic [CH_W-1:0]           ch_reg, ch_next;
    logic                      eight_reg, eight_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic signed [WGT_W-1:0]   w_reg, w_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic signed [WGT_W-1:0]   rd_w_reg, rd_w_next;
    logic                      prod_vld_reg, prod_vld_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      zero_reg, zero_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]       m_data_reg, m_data_next;
    logic                      m_sat_reg, m_sat_next;

    logic [MEM_DEPTH-1:0]      ent_vld_reg;
    logic [SAMPLE_W-1:0]       mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0]       mem_q_reg;
    logic                      mem_qv_reg;
    logic                      mem_we;
    logic [ADDR_W-1:0]         waddr;
    logic [ADDR_W-1:0]         raddr;
    logic signed [SAMPLE_W-1:0] rd_sample;

    logic [CNT_W-1:0]          n_cur;
    logic                      div_start;
    logic                      div_done;
    logic [ACC_W-1:0]          div_q;
    logic                      div_neg;
    logic [SAMPLE_W-1:0]       pred;
    logic                      sat;
    pos_t                      start_idx;

    assign s_tready = (state_reg == S_IDLE);
    assign mem_we   = in_xfer && (in_action == ACT_PUSH) && ch_ok;
    assign waddr    = {in_channel, wp_reg};
    assign raddr    = {ch_reg, idx_reg};
    assign n_cur    = eight_reg ? CNT_W'(8) : CNT_W'(4);
    assign rd_sample = mem_qv_reg ? $signed(mem_q_reg) : '0;
    assign start_idx = (POS_W + 1)'(wp_reg) >= (POS_W + 1)'(in_n)
                     ? POS_W'(wp_reg - POS_W'(in_n))
                     : POS_W'((POS_W + 1)'(wp_reg) + (POS_W + 1)'(HISTORY_DEPTH)
                              - (POS_W + 1)'(in_n));
    assign div_start = (state_reg == S_FIT) && (issue_reg == n_cur)
                     && !rd_vld_reg && !prod_vld_reg;

    always_comb begin
        sat  = 1'b0;
        pred = '0;
        if (div_neg) begin
            if (div_q > ACC_W'(33'h0_8000_0000)) begin
                sat  = 1'b1;
                pred = 32'h8000_0000;
            end else begin
                pred = -div_q[SAMPLE_W-1:0];
            end
        end else begin
            if (div_q > ACC_W'(33'h0_7FFF_FFFF)) begin
                sat  = 1'b1;
                pred = 32'h7FFF_FFFF;
            end else begin
                pred = div_q[SAMPLE_W-1:0];
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        idx_next      = idx_reg;
        ch_next       = ch_reg;
        eight_next    = eight_reg;
        issue_next    = issue_reg;
        w_next        = w_reg;
        rd_vld_next   = 1'b0;
        rd_w_next     = w_reg;
        prod_vld_next = rd_vld_reg;
        prod_next     = PROD_W'(rd_w_reg) * PROD_W'(rd_sample);
        acc_next      = prod_vld_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
        zero_next     = zero_reg;
        m_tvalid_next = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_sat_next    = m_sat_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    case (in_action)
                        ACT_ADVANCE: begin
                            wp_next = (wp_reg == POS_W'(HISTORY_DEPTH - 1))
                                    ? '0 : wp_reg + 1'b1;
                        end
                        ACT_EXTRAP: begin
                            ch_next    = in_channel;
                            eight_next = in_eight;
                            idx_next   = start_idx;
                            issue_next = '0;
                            w_next     = in_eight ? WGT0_8 : WGT0_4;
                            acc_next   = '0;
                            zero_next  = !ch_ok;
                            state_next = ch_ok ? S_FIT : S_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIT: begin
                if (issue_reg != n_cur) begin
                    rd_vld_next = 1'b1;
                    rd_w_next   = w_reg;
                    w_next      = w_reg + WGT_STEP;
                    issue_next  = issue_reg + 1'b1;
                    idx_next    = (idx_reg == POS_W'(HISTORY_DEPTH - 1))
                                ? '0 : idx_reg + 1'b1;
                end else if (div_start) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = zero_reg ? '0 : pred;
                    m_sat_next    = zero_reg ? 1'b0 : sat;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wp_reg       <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            ent_vld_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            prod_vld_reg <= prod_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (mem_we) begin
                ent_vld_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        ch_reg     <= ch_next;
        eight_reg  <= eight_next;
        w_reg      <= w_next;
        rd_w_reg   <= rd_w_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        zero_reg   <= zero_next;
        m_data_reg <= m_data_next;
        m_sat_reg  <= m_sat_next;
    end

    // sample store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= in_sample;
        end
        mem_q_reg  <= mem[raddr];
        mem_qv_reg <= ent_vld_reg[raddr];
    end

    lsle_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .eight    (eight_reg),
        .done     (div_done),
        .quotient (div_q),
        .negative (div_neg)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

endmodule

// File: src/lsle_div.sv
// ============================================================================
// lsle_div
// Division of a signed accumulator by N(N-1) (12 or 56): the factor of four or
// eight is shifted out, then the magnitude is divided by three or seven in two
// digits through one reciprocal multiplier. Gives the magnitude of the
// quotient truncated toward zero and its sign.
// ============================================================================
module lsle_div
    import lsle_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic                    eight,
    output logic                    done,
    output logic [ACC_W-1:0]        quotient,
    output logic                    negative
);

    localparam int NUM_W   = ACC_W - 2;
    localparam int DIG_W   = NUM_W / 2;
    localparam int REM_W   = 3;
    localparam int T_W     = DIG_W + REM_W;
    localparam int RCP_W   = 24;
    localparam int RECIP_K = 25;
    localparam int MUL_W   = T_W + RCP_W;
    localparam int QT_W    = MUL_W - RECIP_K;

    // ceil(2^25 / d): exact floor division for operands below 2^22
    localparam logic [RCP_W-1:0] RECIP_3 = RCP_W'((2 ** RECIP_K + 2) / 3);
    localparam logic [RCP_W-1:0] RECIP_7 = RCP_W'((2 ** RECIP_K + 6) / 7);
    localparam logic [REM_W-1:0] DIV_3   = REM_W'(3);
    localparam logic [REM_W-1:0] DIV_7   = REM_W'(7);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              step_reg, step_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic              eight_reg, eight_next;
    logic              neg_reg, neg_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIG_W-1:0]  qhi_reg, qhi_next;
    logic [DIG_W-1:0]  qlo_reg, qlo_next;

    logic [ACC_W-1:0]  mag;
    logic [ACC_W-1:0]  mag_sh;
    logic [T_W-1:0]    t;
    logic [RCP_W-1:0]  recip;
    logic [REM_W-1:0]  dsel;
    logic [MUL_W-1:0]  prod;
    logic [QT_W-1:0]   qt;
    logic [T_W-1:0]    qd;
    logic [T_W-1:0]    rt;

    assign mag    = dividend[ACC_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
    assign mag_sh = eight ? (mag >> 3) : (mag >> 2);
    assign recip  = eight_reg ? RECIP_7 : RECIP_3;
    assign dsel   = eight_reg ? DIV_7 : DIV_3;
    assign t      = step_reg ? {rem_reg, num_reg[DIG_W-1:0]}
                             : T_W'(num_reg[NUM_W-1:DIG_W]);
    assign prod   = MUL_W'(t) * MUL_W'(recip);
    assign qt     = prod[MUL_W-1:RECIP_K];
    assign qd     = T_W'(qt) * T_W'(dsel);
    assign rt     = t - qd;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        num_next   = num_reg;
        eight_next = eight_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        qhi_next   = qhi_reg;
        qlo_next   = qlo_reg;
        if (start) begin
            busy_next  = 1'b1;
            step_next  = 1'b0;
            num_next   = mag_sh[NUM_W-1:0];
            eight_next = eight;
            neg_next   = dividend[ACC_W-1];
        end else if (busy_reg) begin
            if (!step_reg) begin
                qhi_next  = qt[DIG_W-1:0];
                rem_next  = rt[REM_W-1:0];
                step_next = 1'b1;
            end else begin
                qlo_next  = qt[DIG_W-1:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg   <= num_next;
        eight_reg <= eight_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        qhi_reg   <= qhi_next;
        qlo_reg   <= qlo_next;
    end

    assign done     = done_reg;
    assign quotient = ACC_W'({qhi_reg, qlo_reg});
    assign negative = neg_reg;

endmodule
